/* src/swma_pkg.sv */
// shared constants, codes and item types for the stack with middle access
`default_nettype none
package swma_pkg;

   // stack geometry
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);

   // field widths
   localparam int DATA_W  = 32;
   localparam int FUNC_W  = 2;
   localparam int COUNT_W = 5;
   localparam int STAT_W  = 2;

   // operation codes
   typedef enum logic [FUNC_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_DELMID = 2'd2
   } op_type;

   // status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // one input item
   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] value;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic signed [DATA_W-1:0] middle_value;
      logic                     middle_valid;
      logic [COUNT_W-1:0]       entry_count;
      logic [STAT_W-1:0]        status;
   } rsp_item_type;

endpackage
`default_nettype wire

/* src/swma_if.sv */
// valid/ready channel interfaces for the request and response items
`default_nettype none
interface swma_req_if import swma_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [FUNC_W-1:0]        func;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface swma_rsp_if import swma_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] middle_value;
   logic                     middle_valid;
   logic [COUNT_W-1:0]       entry_count;
   logic [STAT_W-1:0]        status;

   modport source (output valid, output middle_value, output middle_valid,
                   output entry_count, output status, input ready);
   modport sink   (input valid, input middle_value, input middle_valid,
                   input entry_count, input status, output ready);
endinterface
`default_nettype wire

/* src/swma_core.sv */
// stack storage, occupancy and the per-operation update and middle lookup
`default_nettype none
module swma_core import swma_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_item_type item,
   output rsp_item_type      result
);

   logic signed [DATA_W-1:0] cells_ff [DEPTH];
   logic signed [DATA_W-1:0] cells_in [DEPTH];
   logic [OCC_W-1:0]         occ_ff;
   logic [OCC_W-1:0]         occ_in;
   logic [OCC_W-1:0]         mid_old;
   logic [OCC_W-1:0]         mid_new;
   status_type               status;

   // apply the operation to a copy of the stack
   always_comb begin
      cells_in = cells_ff;
      occ_in   = occ_ff;
      status   = ST_OK;
      mid_old  = occ_ff >> 1;
      unique case (item.func)
         OP_PUSH: begin
            if (occ_ff == OCC_W'(DEPTH)) begin
               status = ST_FULL;
            end else begin
               cells_in[occ_ff[IDX_W-1:0]] = item.value;
               occ_in = occ_ff + 1'b1;
            end
         end
         OP_POP: begin
            if (occ_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               occ_in = occ_ff - 1'b1;
            end
         end
         OP_DELMID: begin
            if (occ_ff == '0) begin
               status = ST_EMPTY;
            end else begin
               // every cell from the middle up to just below the top takes its upper neighbor
               for (int i = 0; i < DEPTH - 1; i++) begin
                  if (OCC_W'(i) >= mid_old && OCC_W'(i + 1) < occ_ff) begin
                     cells_in[i] = cells_ff[i + 1];
                  end
               end
               occ_in = occ_ff - 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // middle of the updated stack
   always_comb begin
      mid_new             = occ_in >> 1;
      result.middle_valid = (occ_in != '0);
      result.middle_value = result.middle_valid ? cells_in[mid_new[IDX_W-1:0]] : '0;
      result.entry_count  = COUNT_W'(occ_in);
      result.status       = status;
   end

   // occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (step) begin
         occ_ff <= occ_in;
      end
   end

   // cell storage
   always_ff @(posedge clock) begin
      if (step) begin
         cells_ff <= cells_in;
      end
   end

endmodule
`default_nettype wire

/* src/stack_with_middle_access.sv */
// Stack with middle access: bounded stack of signed 32-bit values.
//
// Request channel (req_if) carries func (0 push, 1 pop, 2 delete middle) and
// value. Each item yields exactly one response item on rsp_if with the middle
// entry after the operation (position floor(count/2) from the bottom), its
// valid flag, the entry count and a status (0 ok, 1 push rejected because
// full, 2 pop or delete on an empty stack ignored). Code 3 changes nothing.
//
// An item is taken into an input register; when the output register is free
// or draining, the operation is applied to the 16-entry register stack and the
// response is loaded into the output register, which drives rsp valid. One
// item per cycle is sustained while rsp ready stays high, limited by the
// single update of the stack registers per cycle.
//
// Reset empties the stack and drops any item in flight. When the receiver
// holds rsp ready low, the response waits in the output register, one more
// item is held in the input register, and req ready then goes low.
`default_nettype none
module stack_with_middle_access import swma_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   swma_req_if.sink  req_if,
   swma_rsp_if.source rsp_if
);

   logic         req_vld_ff;
   req_item_type req_item_ff;
   logic         rsp_vld_ff;
   rsp_item_type rsp_item_ff;
   rsp_item_type result;
   logic         step;

   // process the held item when the output register is free or draining
   assign step         = req_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign req_if.ready = !req_vld_ff || step;

   // input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_if.ready) begin
         req_vld_ff <= req_if.valid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         req_item_ff.func  <= req_if.func;
         req_item_ff.value <= req_if.value;
      end
   end

   swma_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (req_item_ff),
      .result (result)
   );

   // output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (step) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_item_ff <= result;
      end
   end

   // response channel
   assign rsp_if.valid        = rsp_vld_ff;
   assign rsp_if.middle_value = rsp_item_ff.middle_value;
   assign rsp_if.middle_valid = rsp_item_ff.middle_valid;
   assign rsp_if.entry_count  = rsp_item_ff.entry_count;
   assign rsp_if.status       = rsp_item_ff.status;

endmodule
`default_nettype wire
